// ===== hw/rtl/csb_pkg.sv =====
// csb_pkg: shared constants, codes and controller/datapath types
// for the csr build and row product block; no dependencies
package csb_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_NZ   = 4096;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int LIM_W    = ROW_W + 1;
    localparam int NZ_W     = $clog2(MAX_NZ);
    localparam int CNT_W    = NZ_W + 1;
    localparam int CFG_W    = 11;
    localparam int VAL_W    = 32;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int ACC_W    = PROD_W + NZ_W + 1;
    localparam int FRAC     = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_ROWS);
    localparam logic [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (FRAC - 1);

    typedef enum logic [1:0] {
        FUNC_LOAD_NZ,
        FUNC_LOAD_VEC,
        FUNC_QUERY,
        FUNC_CLEAR
    } t_func;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ORDER,
        ST_RANGE,
        ST_FULL
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_INIT_STEP,
        OP_FILL_START,
        OP_FILL_STEP,
        OP_LOAD_COMMIT,
        OP_VEC_WRITE,
        OP_CLEAR,
        OP_RD_START,
        OP_RD_END,
        OP_SET_RANGE,
        OP_RD_NZ,
        OP_RD_VEC,
        OP_MUL,
        OP_ACC,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic keep_code;
    } t_dp_cmd;

    typedef struct packed {
        t_func   func;
        t_status code;
        logic    empty_query;
        logic    fill_done;
        logic    scan_done;
        logic    init_done;
    } t_dp_sts;

endpackage

// ===== hw/rtl/csb_if.sv =====
// csb_if: valid/ready channel interfaces for items and results
// depends on csb_pkg for field widths
interface csb_in_if import csb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        column;
    logic [ROW_W-1:0]        vector_index;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, func, row, column, vector_index, value, input ready);
    modport sink   (input valid, func, row, column, vector_index, value, output ready);
endinterface

interface csb_out_if import csb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [ROW_W-1:0]        row_out;
    logic signed [VAL_W-1:0] dot;

    modport source (output valid, status, row_out, dot, input ready);
    modport sink   (input valid, status, row_out, dot, output ready);
endinterface

// ===== hw/rtl/csb_dp.sv =====
// csb_dp: datapath with row pointer, nonzero and vector memories,
// multiplier and accumulator; depends on csb_pkg
module csb_dp import csb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [LIM_W-1:0]        i_lim,
    input  logic [1:0]              i_func,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [ROW_W-1:0]        i_column,
    input  logic [ROW_W-1:0]        i_vector_index,
    input  logic signed [VAL_W-1:0] i_value,
    output t_dp_sts                 o_sts,
    output logic [1:0]              o_status,
    output logic [ROW_W-1:0]        o_row_out,
    output logic signed [VAL_W-1:0] o_dot
);

    logic [CNT_W-1:0] r_row_end [MAX_ROWS];
    logic [ROW_W-1:0] r_col_mem [MAX_NZ];
    logic [VAL_W-1:0] r_val_mem [MAX_NZ];
    logic [VAL_W-1:0] r_vec_mem [MAX_ROWS];

    t_func                   r_func;
    logic [ROW_W-1:0]        r_row, r_col, r_vidx;
    logic [VAL_W-1:0]        r_val;
    logic [CNT_W-1:0]        r_count;
    logic [ROW_W-1:0]        r_last_row;
    logic                    r_row0_valid;
    logic [LIM_W-1:0]        r_j;
    logic [CNT_W-1:0]        r_k, r_kend, r_re_q;
    logic [ROW_W-1:0]        r_col_q;
    logic [VAL_W-1:0]        r_val_q, r_vec_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    t_status                 r_code;
    t_status                 code;
    logic [ROW_W-1:0]        re_addr;
    logic [CNT_W-1:0]        n_start, n_end;
    logic signed [ACC_W-1:0] rnd, shd;
    logic [VAL_W-1:0]        sat;
    logic [ACC_W-VAL_W:0]    top_bits;

    // status of the captured item
    always_comb begin
        code = ST_OK;
        unique case (r_func)
            FUNC_LOAD_NZ: begin
                if (({1'b0, r_row} >= i_lim) || ({1'b0, r_col} >= i_lim)) begin
                    code = ST_RANGE;
                end else if (r_row < r_last_row) begin
                    code = ST_ORDER;
                end else if (r_count >= CNT_W'(MAX_NZ)) begin
                    code = ST_FULL;
                end
            end
            FUNC_LOAD_VEC: begin
                if ({1'b0, r_vidx} >= i_lim) code = ST_RANGE;
            end
            FUNC_QUERY: begin
                if ({1'b0, r_row} >= i_lim) code = ST_RANGE;
            end
            FUNC_CLEAR: code = ST_OK;
        endcase
    end

    assign o_sts.func        = r_func;
    assign o_sts.code        = code;
    assign o_sts.empty_query = (r_count == '0) || (r_row > r_last_row);
    assign o_sts.fill_done   = r_j >= {1'b0, r_row};
    assign o_sts.scan_done   = r_k >= r_kend;
    assign o_sts.init_done   = r_j[LIM_W-1];

    assign re_addr = (i_cmd.op == OP_RD_START) ? r_row - ROW_W'(1) : r_row;
    // row 0 starts at pointer 0; an unwritten row 0 reads as empty
    assign n_start = ((r_row == '0) || ((r_row == ROW_W'(1)) && !r_row0_valid)) ? '0 : r_re_q;
    assign n_end   = ((r_row == '0) && !r_row0_valid) ? '0 :
                     ((r_re_q > r_count) ? r_count : r_re_q);

    // round half up, then saturate to q16.16
    assign rnd      = r_acc + $signed(RND_HALF);
    assign shd      = rnd >>> FRAC;
    assign top_bits = shd[ACC_W-1:VAL_W-1];
    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            sat = shd[VAL_W-1:0];
        end else if (shd[ACC_W-1]) begin
            sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FILL_STEP) begin
            r_row_end[r_j[ROW_W-1:0]] <= r_count;
        end else if (i_cmd.op == OP_LOAD_COMMIT) begin
            r_row_end[r_row] <= r_count + CNT_W'(1);
        end
        if ((i_cmd.op == OP_RD_START) || (i_cmd.op == OP_RD_END)) begin
            r_re_q <= r_row_end[re_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD_COMMIT) begin
            r_col_mem[r_count[NZ_W-1:0]] <= r_col;
            r_val_mem[r_count[NZ_W-1:0]] <= r_val;
        end
        if (i_cmd.op == OP_RD_NZ) begin
            r_col_q <= r_col_mem[r_k[NZ_W-1:0]];
            r_val_q <= r_val_mem[r_k[NZ_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_INIT_STEP) begin
            r_vec_mem[r_j[ROW_W-1:0]] <= '0;
        end else if (i_cmd.op == OP_VEC_WRITE) begin
            r_vec_mem[r_vidx] <= r_val;
        end
        if (i_cmd.op == OP_RD_VEC) begin
            r_vec_q <= r_vec_mem[r_col_q];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_row   <= '0;
            r_row0_valid <= 1'b0;
            r_j          <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_INIT_STEP:  r_j <= r_j + LIM_W'(1);
                OP_FILL_START: r_j <= {1'b0, r_last_row} + LIM_W'(1);
                OP_FILL_STEP:  r_j <= r_j + LIM_W'(1);
                OP_LOAD_COMMIT: begin
                    r_count    <= r_count + CNT_W'(1);
                    r_last_row <= r_row;
                    if (r_row == '0) r_row0_valid <= 1'b1;
                end
                OP_CLEAR: begin
                    r_count      <= '0;
                    r_last_row   <= '0;
                    r_row0_valid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // item, scan and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.keep_code) r_code <= code;
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_func <= t_func'(i_func);
                r_row  <= i_row;
                r_col  <= i_column;
                r_vidx <= i_vector_index;
                r_val  <= i_value;
                r_acc  <= '0;
            end
            OP_RD_END:    r_k <= n_start;
            OP_SET_RANGE: r_kend <= n_end;
            OP_RD_NZ:     r_k <= r_k + CNT_W'(1);
            OP_MUL:       r_prod <= $signed(r_val_q) * $signed(r_vec_q);
            OP_ACC:       r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            OP_FINISH: begin
                o_status  <= r_code;
                o_row_out <= r_row;
                o_dot     <= sat;
            end
            default: ;
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NZ))
        else $error("nonzero count beyond store size");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_CLEAR) |=> (r_count == '0) && !r_row0_valid)
        else $error("clear left nonzeros behind");

    a_fill_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FILL_STEP) |-> (r_j < {1'b0, r_row}) && (r_j > {1'b0, r_last_row}))
        else $error("fill outside skipped rows");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_RD_NZ) |-> (r_k < r_kend) && (r_kend <= r_count))
        else $error("scan beyond row end");

endmodule

// ===== hw/rtl/csb_ctrl.sv =====
// csb_ctrl: sequencing state machine for loads, queries, clear and
// the vector clearing pass; depends on csb_pkg
module csb_ctrl import csb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_FILL, S_QA, S_QB,
        S_NZ, S_VEC, S_MUL, S_ACC, S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   ok, can_finish;

    assign ok         = (i_sts.code == ST_OK);
    assign can_finish = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.op        = OP_NONE;
        o_cmd.keep_code = (r_state == S_DECODE);
        n_state         = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_sts.init_done) n_state = S_IDLE;
                else o_cmd.op = OP_INIT_STEP;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESP;
                unique case (i_sts.func)
                    FUNC_LOAD_NZ: begin
                        if (ok) begin
                            o_cmd.op = OP_FILL_START;
                            n_state  = S_FILL;
                        end
                    end
                    FUNC_LOAD_VEC: if (ok) o_cmd.op = OP_VEC_WRITE;
                    FUNC_QUERY: begin
                        if (ok && !i_sts.empty_query) begin
                            o_cmd.op = OP_RD_START;
                            n_state  = S_QA;
                        end
                    end
                    FUNC_CLEAR: o_cmd.op = OP_CLEAR;
                endcase
            end
            S_FILL: begin
                if (i_sts.fill_done) begin
                    o_cmd.op = OP_LOAD_COMMIT;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_FILL_STEP;
                end
            end
            S_QA: begin
                o_cmd.op = OP_RD_END;
                n_state  = S_QB;
            end
            S_QB: begin
                o_cmd.op = OP_SET_RANGE;
                n_state  = S_NZ;
            end
            S_NZ: begin
                if (i_sts.scan_done) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.op = OP_RD_NZ;
                    n_state  = S_VEC;
                end
            end
            S_VEC: begin
                o_cmd.op = OP_RD_VEC;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = S_NZ;
            end
            S_RESP: begin
                if (can_finish) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_RESP) && can_finish) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/csr_build_and_spmv.sv =====
// csr_build_and_spmv: top level, compressed sparse row builder with row dot product
// depends on csb_pkg, csb_if, csb_ctrl, csb_dp
//
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+----------------------------------------
// i_in     | in  | valid / ready         | func, row, column, vector_index, value
// o_out    | out | valid / ready         | status, row_out, dot
// cfg      | in  | i_cfg_valid/o_cfg_ready | i_cfg_data = rows_in_use
//
// after reset the vector store is swept to zero; no transaction is taken meanwhile
// load vector, clear, errors: capture, decode, respond
// load nonzero: capture, decode, a fill step per skipped row, commit, respond
// query: pointer reads, then per nonzero: read, vector read, multiply, accumulate
// the next transaction is taken while a result still waits on o_out;
// a stalled o_out holds the block only when the next result is ready
module csr_build_and_spmv import csb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    csb_in_if.sink           i_in,
    csb_out_if.source        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_rows_in_use;
    logic [LIM_W-1:0] lim;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    // configuration register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_rows_in_use <= i_cfg_data;
        end
    end

    // limit clamps at the store depth
    assign lim = (r_rows_in_use > CFG_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                     : LIM_W'(r_rows_in_use);

    csb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    csb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_lim          (lim),
        .i_func         (i_in.func),
        .i_row          (i_in.row),
        .i_column       (i_in.column),
        .i_vector_index (i_in.vector_index),
        .i_value        (i_in.value),
        .o_sts          (sts),
        .o_status       (o_out.status),
        .o_row_out      (o_out.row_out),
        .o_dot          (o_out.dot)
    );

endmodule
